// File: rtl/mse_pkg.sv
package mse_pkg;

    localparam logic [3:0] OP_J     = 4'd0;
    localparam logic [3:0] OP_JAL   = 4'd1;
    localparam logic [3:0] OP_JR    = 4'd2;
    localparam logic [3:0] OP_LW    = 4'd3;
    localparam logic [3:0] OP_SW    = 4'd4;
    localparam logic [3:0] OP_BEQ   = 4'd5;
    localparam logic [3:0] OP_ADD   = 4'd6;
    localparam logic [3:0] OP_ADDI  = 4'd7;
    localparam logic [3:0] OP_ADDIU = 4'd8;
    localparam logic [3:0] OP_ANDI  = 4'd9;
    localparam logic [3:0] OP_ORI   = 4'd10;
    localparam logic [3:0] OP_XORI  = 4'd11;
    localparam logic [3:0] OP_SLTI  = 4'd12;
    localparam logic [3:0] OP_LUI   = 4'd13;
    localparam logic [3:0] OP_MUL   = 4'd14;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_LINK = 5'd31;

    typedef struct packed {
        logic [31:0] pc;
        logic        taken;
        logic        fault;
        logic        wr;
        logic [4:0]  dst;
        logic [31:0] val;
        logic        load;
        logic        mem_rd;
        logic        mem_we;
        logic [29:0] mem_addr;
    } exec_t;

endpackage

// File: rtl/mse_regfile.sv
module mse_regfile import mse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [4:0]  rd_a_addr,
    input  logic [4:0]  rd_b_addr,
    output logic [31:0] rd_a_data,
    output logic [31:0] rd_b_data,
    input  logic        wr_en,
    input  logic [4:0]  wr_addr,
    input  logic [31:0] wr_data
);

    logic [31:0] rf_reg [32];
    logic [31:0] valid_reg;
    logic [31:0] a_data_reg;
    logic [31:0] b_data_reg;
    logic        a_vld_reg;
    logic        b_vld_reg;
    logic        a_hit;
    logic        b_hit;

    // write-through on a read that lands on the same edge as a write
    assign a_hit = wr_en && (wr_addr == rd_a_addr) && (wr_addr != REG_ZERO);
    assign b_hit = wr_en && (wr_addr == rd_b_addr) && (wr_addr != REG_ZERO);

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_addr != REG_ZERO)
        begin
            rf_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            a_data_reg <= a_hit ? wr_data : rf_reg[rd_a_addr];
            b_data_reg <= b_hit ? wr_data : rf_reg[rd_b_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_addr != REG_ZERO)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                a_vld_reg <= valid_reg[rd_a_addr] | a_hit;
                b_vld_reg <= valid_reg[rd_b_addr] | b_hit;
            end
        end
    end

    assign rd_a_data = a_vld_reg ? a_data_reg : 32'd0;
    assign rd_b_data = b_vld_reg ? b_data_reg : 32'd0;

endmodule

// File: rtl/mse_datamem.sv
module mse_datamem import mse_pkg::*;
#(
    parameter int MEM_WORDS = 1024,
    parameter int AW        = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    output logic          clr_done
);

    logic [31:0]   mem_reg [MEM_WORDS];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          clr_done_reg;
    logic          clr_done_next;
    logic          we;
    logic [AW-1:0] wa;
    logic [31:0]   wd;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MEM_WORDS - 1))
            begin
                clr_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_done_reg <= clr_done_next;
        end
    end

    assign we = !clr_done_reg || wr_en;
    assign wa = clr_done_reg ? wr_addr : clr_cnt_reg;
    assign wd = clr_done_reg ? wr_data : 32'd0;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_done = clr_done_reg;

endmodule

// File: rtl/mse_exec.sv
module mse_exec import mse_pkg::*;
#(
    parameter int MEM_WORDS = 1024
)
(
    input  logic [3:0]  op,
    input  logic [4:0]  rf,
    input  logic [15:0] imm,
    input  logic [25:0] target,
    input  logic [31:0] pc,
    input  logic [31:0] opa,
    input  logic [31:0] opb,
    output exec_t       res
);

    logic [31:0] imm32;
    logic [31:0] addr;
    logic        addr_ok;
    logic [31:0] prod;

    assign imm32   = {{16{imm[15]}}, imm};
    assign addr    = opa + imm32;
    assign addr_ok = !addr[31] && (addr[1:0] == 2'b00) && (addr[31:2] < 30'(MEM_WORDS));
    assign prod    = opa * opb;

    always_comb
    begin
        res          = '0;
        res.pc       = pc;
        res.dst      = rf;
        res.mem_addr = addr[31:2];
        case (op)
            OP_J:
            begin
                res.pc = {6'd0, target};
            end
            OP_JAL:
            begin
                res.wr  = 1'b1;
                res.dst = REG_LINK;
                res.val = pc + 32'd1;
                res.pc  = {6'd0, target};
            end
            OP_JR:
            begin
                res.pc = opb;
            end
            OP_LW:
            begin
                if (addr_ok)
                begin
                    res.wr     = 1'b1;
                    res.load   = 1'b1;
                    res.mem_rd = 1'b1;
                end
                else
                begin
                    res.fault = 1'b1;
                end
            end
            OP_SW:
            begin
                if (addr_ok)
                begin
                    res.mem_we = 1'b1;
                end
                else
                begin
                    res.fault = 1'b1;
                end
            end
            OP_BEQ:
            begin
                res.taken = (opb == opa);
            end
            OP_ADD:
            begin
                res.wr  = 1'b1;
                res.val = opa + opb;
            end
            OP_ADDI, OP_ADDIU:
            begin
                res.wr  = 1'b1;
                res.val = addr;
            end
            OP_ANDI:
            begin
                res.wr  = 1'b1;
                res.val = opa & imm32;
            end
            OP_ORI:
            begin
                res.wr  = 1'b1;
                res.val = opa | imm32;
            end
            OP_XORI:
            begin
                res.wr  = 1'b1;
                res.val = opa ^ imm32;
            end
            OP_SLTI:
            begin
                res.wr  = 1'b1;
                res.val = {31'd0, ($signed(opa) < $signed(imm32))};
            end
            OP_LUI:
            begin
                res.wr  = 1'b1;
                res.val = {imm, 16'd0};
            end
            OP_MUL:
            begin
                res.wr  = 1'b1;
                res.val = prod;
            end
            default:
            begin
                res.pc = pc;
            end
        endcase
        if (res.dst == REG_ZERO)
        begin
            res.wr     = 1'b0;
            res.load   = 1'b0;
            res.mem_rd = 1'b0;
        end
        if (!res.wr)
        begin
            res.dst = REG_ZERO;
            res.val = 32'd0;
        end
    end

endmodule

// File: rtl/mips_subset_instruction_executor_unit.sv
// Executes one decoded instruction per input beat against a 32-entry
// register file, a MEM_WORDS-word data memory and a program counter.
// Input channel: in_valid/in_ready with the decoded fields. Output channel:
// out_valid/out_ready with one result beat per instruction, in order.
// An accepted instruction passes the s1 registers (with the register file read),
// the s2 result register (with the data memory read) and the output register
// before out_valid. No new instruction is taken while one sits in s1; the
// next read may overlap the register write back, with write-through forwarding.
// The result register lets the next instruction enter while a result still
// waits; if out_ready stays low the finished instruction holds in its stage
// and in_ready drops until the result beat is taken.
// Reset: registers, PC and flags clear at once; the data memory is cleared
// by a sweep over all MEM_WORDS words after reset, during which in_ready is low.
module mips_subset_instruction_executor_unit import mse_pkg::*;
#(
    parameter int MEM_WORDS = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         req_type,
    input  logic [4:0]         reg_first,
    input  logic [4:0]         reg_second,
    input  logic [4:0]         reg_third,
    input  logic signed [15:0] imm_value,
    input  logic [25:0]        jump_target,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_pc,
    output logic               branch_taken,
    output logic               mem_fault,
    output logic               reg_written,
    output logic [4:0]         written_reg,
    output logic signed [31:0] written_value
);

    localparam int AW = $clog2(MEM_WORDS);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [3:0]  s1_op_reg;
    logic [4:0]  s1_rf_reg;
    logic [15:0] s1_imm_reg;
    logic [25:0] s1_target_reg;
    logic        s2_valid_reg;
    logic        s2_valid_next;
    exec_t       s2_res_reg;
    logic [31:0] pc_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_pc_reg;
    logic        out_taken_reg;
    logic        out_fault_reg;
    logic        out_wr_reg;
    logic [4:0]  out_dst_reg;
    logic [31:0] out_val_reg;

    logic        in_accept;
    logic        out_free;
    logic        s1_adv;
    logic        s2_adv;
    logic        clr_done;
    logic [4:0]  rd_b_addr;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [31:0] mem_rdata;
    logic [31:0] wb_val;
    exec_t       ex;

    assign out_free  = !out_valid_reg || out_ready;
    assign s2_adv    = s2_valid_reg && out_free;
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign in_ready  = clr_done && !s1_valid_reg && (!s2_valid_reg || out_free);
    assign in_accept = in_valid && in_ready;

    assign rd_b_addr = (req_type == OP_ADD || req_type == OP_MUL) ? reg_third : reg_first;
    assign wb_val    = s2_res_reg.load ? mem_rdata : s2_res_reg.val;

    mse_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_a_addr (reg_second),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (opa),
        .rd_b_data (opb),
        .wr_en     (s2_adv && s2_res_reg.wr),
        .wr_addr   (s2_res_reg.dst),
        .wr_data   (wb_val)
    );

    mse_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .op     (s1_op_reg),
        .rf     (s1_rf_reg),
        .imm    (s1_imm_reg),
        .target (s1_target_reg),
        .pc     (pc_reg),
        .opa    (opa),
        .opb    (opb),
        .res    (ex)
    );

    mse_datamem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_datamem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (s1_adv && ex.mem_rd),
        .rd_addr  (ex.mem_addr[AW-1:0]),
        .rd_data  (mem_rdata),
        .wr_en    (s1_adv && ex.mem_we),
        .wr_addr  (ex.mem_addr[AW-1:0]),
        .wr_data  (opb),
        .clr_done (clr_done)
    );

    always_comb
    begin
        s1_valid_next  = in_accept || (s1_valid_reg && !s1_adv);
        s2_valid_next  = s1_adv || (s2_valid_reg && !s2_adv);
        out_valid_next = s2_adv || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                pc_reg <= ex.pc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= req_type;
            s1_rf_reg     <= reg_first;
            s1_imm_reg    <= imm_value;
            s1_target_reg <= jump_target;
        end
        if (s1_adv)
        begin
            s2_res_reg <= ex;
        end
        if (s2_adv)
        begin
            out_pc_reg    <= s2_res_reg.pc;
            out_taken_reg <= s2_res_reg.taken;
            out_fault_reg <= s2_res_reg.fault;
            out_wr_reg    <= s2_res_reg.wr;
            out_dst_reg   <= s2_res_reg.dst;
            out_val_reg   <= s2_res_reg.wr ? wb_val : 32'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_pc        = out_pc_reg;
    assign branch_taken  = out_taken_reg;
    assign mem_fault     = out_fault_reg;
    assign reg_written   = out_wr_reg;
    assign written_reg   = out_dst_reg;
    assign written_value = out_val_reg;

endmodule

// File: verif/tb_mips_subset_instruction_executor_unit.sv
module tb_mips_subset_instruction_executor_unit import mse_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MEM_WORDS   = 1024;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [3:0]  OP_NONE     = 4'd15;

    typedef struct packed {
        logic [3:0]         op;
        logic [4:0]         rf;
        logic [4:0]         rs;
        logic [4:0]         rt;
        logic signed [15:0] imm;
        logic [25:0]        target;
    } instr_t;

    typedef struct packed {
        logic [31:0] pc;
        logic        taken;
        logic        fault;
        logic        wr;
        logic [4:0]  dst;
        logic [31:0] val;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    instr_t             in_beat = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] new_pc;
    logic               branch_taken;
    logic               mem_fault;
    logic               reg_written;
    logic [4:0]         written_reg;
    logic signed [31:0] written_value;

    logic [31:0] gpr [32];
    logic [31:0] dmem [MEM_WORDS];
    logic [31:0] pc_q;

    instr_t  instr_queue[$];
    result_t expected_results[$];

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_off = 1'b0;
    int n_accepted = 0;
    int n_errors = 0;
    int cycles = 0;

    mips_subset_instruction_executor_unit #(
        .MEM_WORDS(MEM_WORDS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(in_beat.op),
        .reg_first(in_beat.rf),
        .reg_second(in_beat.rs),
        .reg_third(in_beat.rt),
        .imm_value(in_beat.imm),
        .jump_target(in_beat.target),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .new_pc(new_pc),
        .branch_taken(branch_taken),
        .mem_fault(mem_fault),
        .reg_written(reg_written),
        .written_reg(written_reg),
        .written_value(written_value)
    );

    always #1 clk = ~clk;

    function automatic result_t execute_instr(instr_t ins);
        result_t     r;
        logic [31:0] imm32;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addr;
        logic        addr_ok;
        imm32   = {{16{ins.imm[15]}}, ins.imm};
        a       = gpr[ins.rs];
        b       = gpr[ins.rt];
        addr    = a + imm32;
        addr_ok = !addr[31] && (addr[1:0] == 2'b00) && (addr[31:2] < MEM_WORDS);
        r       = '0;
        r.dst   = ins.rf;
        case (ins.op)
            OP_J:
            begin
                pc_q = {6'b0, ins.target};
            end
            OP_JAL:
            begin
                r.wr  = 1'b1;
                r.dst = REG_LINK;
                r.val = pc_q + 32'd1;
                pc_q  = {6'b0, ins.target};
            end
            OP_JR:
            begin
                pc_q = gpr[ins.rf];
            end
            OP_LW:
            begin
                if (addr_ok)
                begin
                    r.wr  = 1'b1;
                    r.val = dmem[addr[31:2]];
                end
                else
                begin
                    r.fault = 1'b1;
                end
            end
            OP_SW:
            begin
                if (addr_ok)
                    dmem[addr[31:2]] = gpr[ins.rf];
                else
                    r.fault = 1'b1;
            end
            OP_BEQ:   r.taken = (gpr[ins.rf] == a);
            OP_ADD:   begin r.wr = 1'b1; r.val = a + b; end
            OP_ADDI,
            OP_ADDIU: begin r.wr = 1'b1; r.val = a + imm32; end
            OP_ANDI:  begin r.wr = 1'b1; r.val = a & imm32; end
            OP_ORI:   begin r.wr = 1'b1; r.val = a | imm32; end
            OP_XORI:  begin r.wr = 1'b1; r.val = a ^ imm32; end
            OP_SLTI:  begin r.wr = 1'b1; r.val = {31'b0, $signed(a) < $signed(imm32)}; end
            OP_LUI:   begin r.wr = 1'b1; r.val = {ins.imm, 16'h0000}; end
            OP_MUL:   begin r.wr = 1'b1; r.val = a * b; end
            default:  ;
        endcase
        if (r.wr && r.dst == REG_ZERO)
            r.wr = 1'b0;
        if (r.wr)
            gpr[r.dst] = r.val;
        else
        begin
            r.dst = '0;
            r.val = '0;
        end
        r.pc = pc_q;
        return r;
    endfunction

    function automatic instr_t mk(logic [3:0] op, int rf, int rs, int rt, int imm, int tgt);
        instr_t i;
        i.op     = op;
        i.rf     = 5'(rf);
        i.rs     = 5'(rs);
        i.rt     = 5'(rt);
        i.imm    = 16'(imm);
        i.target = 26'(tgt);
        return i;
    endfunction

    // Mostly base-register load/store runs and full-width value setup; the rest is raw noise.
    task automatic add_traffic(int n);
        int cnt;
        int sel;
        int bx;
        int bw;
        int tw;
        int k;
        int rf;
        int imm;
        logic [3:0] op;
        cnt = 0;
        while (cnt < n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
            begin
                bx = $urandom_range(1, 31);
                bw = $urandom_range(0, MEM_WORDS - 1);
                instr_queue.push_back(mk(OP_ADDI, bx, 0, 0, bw * 4, 0));
                cnt++;
                k = $urandom_range(2, 6);
                repeat (k)
                begin
                    op = ($urandom_range(0, 1) == 1) ? OP_SW : OP_LW;
                    rf = $urandom_range(0, 31);
                    if (op == OP_LW && rf == bx)
                        rf = (bx % 31) + 1;
                    if ($urandom_range(0, 3) == 0)
                        tw = $urandom_range(0, MEM_WORDS - 1);
                    else
                        tw = (bw + $urandom_range(0, 7)) % MEM_WORDS;
                    imm = (tw - bw) * 4;
                    case ($urandom_range(0, 19))
                        0: imm = imm + $urandom_range(1, 3);
                        1: imm = (MEM_WORDS - bw + $urandom_range(0, 7)) * 4;
                        2: imm = -(bw + $urandom_range(1, 7)) * 4;
                        default: ;
                    endcase
                    instr_queue.push_back(mk(op, rf, bx, $urandom_range(0, 31), imm,
                                             $urandom_range(0, 26'h3FFFFFF)));
                    cnt++;
                end
            end
            else if (sel < 50)
            begin
                rf = $urandom_range(0, 31);
                instr_queue.push_back(mk(OP_LUI, rf, $urandom_range(0, 31), 0,
                                         $urandom_range(0, 65535), 0));
                instr_queue.push_back(mk(OP_ORI, rf, rf, 0, $urandom_range(0, 65535), 0));
                cnt += 2;
            end
            else
            begin
                op = 4'($urandom_range(0, 15));
                rf = $urandom_range(0, 31);
                bx = $urandom_range(0, 31);
                if (op == OP_BEQ && $urandom_range(0, 1) == 1)
                    bx = rf;
                instr_queue.push_back(mk(op, rf, bx, $urandom_range(0, 31),
                                         $urandom_range(0, 65535),
                                         $urandom_range(0, 26'h3FFFFFF)));
                cnt++;
            end
        end
    endtask

    // sample between edges so the driver and monitor updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (!(instr_queue.size() == 0 && !in_valid && expected_results.size() == 0))
            @(negedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(execute_instr(in_beat));
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (!hold_off && instr_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_beat  <= instr_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: one result beat per accepted instruction, in order
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        got = {new_pc, branch_taken, mem_fault, reg_written, written_reg, written_value};
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                if (n_errors < 10)
                    $display("unexpected result beat: %h", got);
                n_errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    if (n_errors < 10)
                        $display({"result %0d: exp pc=%h tk=%b flt=%b wr=%b rd=%0d val=%h,",
                                  " got pc=%h tk=%b flt=%b wr=%b rd=%0d val=%h"},
                                 n_accepted - expected_results.size() - 1,
                                 want.pc, want.taken, want.fault, want.wr, want.dst, want.val,
                                 got.pc, got.taken, got.fault, got.wr, got.dst, got.val);
                    n_errors++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("mips_subset_instruction_executor_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        int base;
        for (int i = 0; i < 32; i++)
            gpr[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++)
            dmem[i] = '0;
        pc_q = '0;

        instr_queue.push_back(mk(OP_J,     0, 0, 0, 0, 26'h3FFFFFF));
        instr_queue.push_back(mk(OP_JAL,   0, 0, 0, 0, 0));
        instr_queue.push_back(mk(OP_ADDI,  1, 0, 0, 32767, 0));
        instr_queue.push_back(mk(OP_ADDI,  2, 0, 0, -32768, 0));
        instr_queue.push_back(mk(OP_ADDIU, 3, 1, 0, 1, 0));
        instr_queue.push_back(mk(OP_LUI,   4, 0, 0, -32768, 0));
        instr_queue.push_back(mk(OP_LUI,   5, 0, 0, -1, 0));
        instr_queue.push_back(mk(OP_ORI,   5, 5, 0, -1, 0));
        instr_queue.push_back(mk(OP_ADD,   6, 4, 4, 0, 0));
        instr_queue.push_back(mk(OP_MUL,   7, 5, 5, 0, 0));
        instr_queue.push_back(mk(OP_MUL,   8, 4, 1, 0, 0));
        instr_queue.push_back(mk(OP_ANDI,  9, 5, 0, 16'h1234, 0));
        instr_queue.push_back(mk(OP_XORI, 10, 5, 0, -1, 0));
        instr_queue.push_back(mk(OP_SLTI, 11, 4, 0, 0, 0));
        instr_queue.push_back(mk(OP_SLTI, 12, 1, 0, -32768, 0));
        instr_queue.push_back(mk(OP_SW,    5, 0, 0, (MEM_WORDS - 1) * 4, 0));
        instr_queue.push_back(mk(OP_LW,   13, 0, 0, (MEM_WORDS - 1) * 4, 0));
        instr_queue.push_back(mk(OP_SW,    1, 0, 0, MEM_WORDS * 4, 0));
        instr_queue.push_back(mk(OP_LW,   13, 0, 0, -4, 0));
        instr_queue.push_back(mk(OP_LW,   13, 0, 0, 2, 0));
        instr_queue.push_back(mk(OP_LW,   13, 4, 0, 0, 0));
        instr_queue.push_back(mk(OP_BEQ,   1, 1, 0, 8, 0));
        instr_queue.push_back(mk(OP_BEQ,   1, 2, 0, -8, 0));
        instr_queue.push_back(mk(OP_ADDI,  0, 1, 0, 5, 0));
        instr_queue.push_back(mk(OP_JR,    5, 0, 0, 0, 0));
        instr_queue.push_back(mk(OP_JAL,   0, 0, 0, 0, 26'h155AAAA));
        instr_queue.push_back(mk(OP_NONE, 31, 31, 31, -1, 26'h3FFFFFF));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        add_traffic(250);
        wait_drained();

        idle_pct  <= 88;
        stall_pct <= 0;
        add_traffic(250);
        wait_drained();

        idle_pct  <= 0;
        stall_pct <= 88;
        add_traffic(250);
        wait_drained();

        idle_pct  <= 27;
        stall_pct <= 27;
        base = n_accepted;
        add_traffic(250);
        while (n_accepted < base + 100)
            @(posedge clk);
        hold_off <= 1'b1;
        @(posedge clk);
        while (in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        hold_off <= 1'b0;
        wait_drained();

        repeat (20) @(posedge clk);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("mips_subset_instruction_executor_unit: match");
        else
            $display("mips_subset_instruction_executor_unit: mismatch");
        $finish;
    end

endmodule
